// ----- rtl/tfd_pkg.sv -----
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared types and constants of the touch frame decoder.
// ----------------------------------------------------------------------------
package tfd_pkg;

  localparam int FRAME_BYTES  = 8;
  localparam int IDX_W        = $clog2(FRAME_BYTES);
  localparam int RAW_W        = 12;
  localparam int SIZE_W       = 12;
  localparam int COORD_W      = 13;
  localparam int PROD_W       = RAW_W + SIZE_W;
  localparam int SCALE_SHIFT  = 11;
  localparam int CFG_INDEX_W  = 2;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd600;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd800;

  localparam logic [CFG_INDEX_W-1:0] REG_PANEL_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PANEL_HEIGHT = 2'd1;

  localparam logic [1:0] HDR_TAG = 2'b01;
  localparam logic [1:0] CNT_ONE = 2'd1;
  localparam logic [1:0] CNT_TWO = 2'd2;

  typedef struct packed {
    logic             touch;
    logic             two;
    logic [RAW_W-1:0] rx0;
    logic [RAW_W-1:0] ry0;
    logic [RAW_W-1:0] rx1;
    logic [RAW_W-1:0] ry1;
  } job_t;

endpackage

// ----- rtl/tfd_front.sv -----
// ----------------------------------------------------------------------------
// tfd_front
// Frame assembly, checksum, header classification; one job per valid-sum frame.
// ----------------------------------------------------------------------------
module tfd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  frame_start,
  output logic                  push,
  output tfd_pkg::job_t         job
);

  logic [7:0]                frame_bytes [tfd_pkg::FRAME_BYTES];
  logic [tfd_pkg::IDX_W-1:0] byte_index;
  logic [7:0]                running_sum;
  logic [tfd_pkg::IDX_W-1:0] idx_eff;
  logic [7:0]                sum_eff;
  logic [7:0]                sum_new;
  logic                      frame_end;
  logic [7:0]                hdr;

  assign idx_eff   = frame_start ? '0 : byte_index;
  assign sum_eff   = frame_start ? 8'd0 : running_sum;
  assign sum_new   = sum_eff + data_byte;
  assign frame_end = (idx_eff == tfd_pkg::IDX_W'(tfd_pkg::FRAME_BYTES - 1));
  assign push      = accept && frame_end && (sum_new == 8'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      running_sum <= 8'd0;
    end else if (accept) begin
      byte_index  <= idx_eff + 1'b1;
      running_sum <= frame_end ? 8'd0 : sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frame_bytes[idx_eff] <= data_byte;
    end
  end

  assign hdr       = frame_bytes[0];
  assign job.touch = (hdr[7:6] == tfd_pkg::HDR_TAG) &&
                     ((hdr[1:0] == tfd_pkg::CNT_ONE) || (hdr[1:0] == tfd_pkg::CNT_TWO));
  assign job.two   = (hdr[1:0] == tfd_pkg::CNT_TWO);
  assign job.rx0   = {frame_bytes[1][7:4], frame_bytes[2]};
  assign job.ry0   = {frame_bytes[1][3:0], frame_bytes[3]};
  assign job.rx1   = {frame_bytes[4][7:4], frame_bytes[5]};
  assign job.ry1   = {frame_bytes[4][3:0], frame_bytes[6]};

endmodule

// ----- rtl/tfd_fifo.sv -----
// ----------------------------------------------------------------------------
// tfd_fifo
// Short job queue between frame assembly and point reporting.
// ----------------------------------------------------------------------------
module tfd_fifo #(
  parameter int DEPTH = tfd_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tfd_pkg::job_t wr_job,
  output logic          full,
  input  logic          pop,
  output logic          rd_valid,
  output tfd_pkg::job_t rd_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tfd_pkg::job_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

// ----- rtl/tfd_back.sv -----
// ----------------------------------------------------------------------------
// tfd_back
// Point scaling and rotation: multiply stage, then subtract into output register.
// ----------------------------------------------------------------------------
module tfd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [tfd_pkg::SIZE_W-1:0] panel_width,
  input  logic [tfd_pkg::SIZE_W-1:0] panel_height,
  input  logic                       job_valid,
  input  tfd_pkg::job_t              job,
  output logic                       job_pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [31:0]                m_tdata,  // point_x[12:0], point_y[25:13], zero pad
  output logic                       m_tlast,  // last_point
  output logic [1:0]                 m_tuser   // touch_down[0], point_index[1]
);

  localparam int CW = tfd_pkg::COORD_W;

  logic                        sel;
  logic                        issue;
  logic                        more;
  logic                        s1_adv;
  logic                        s2_adv;
  logic [tfd_pkg::RAW_W-1:0]   rx;
  logic [tfd_pkg::RAW_W-1:0]   ry;

  logic                        s1_valid;
  logic [tfd_pkg::PROD_W-1:0]  s1_prod_x;
  logic [tfd_pkg::PROD_W-1:0]  s1_prod_y;
  logic                        s1_down;
  logic                        s1_idx;
  logic                        s1_last;

  logic [CW-1:0]               sx;
  logic [CW-1:0]               sy;
  logic [CW-1:0]               w_ext;
  logic [CW-1:0]               py;
  logic [CW-1:0]               point_x;
  logic [CW-1:0]               point_y;
  logic                        touch_down;
  logic                        point_index;

  assign s2_adv  = !m_tvalid || m_tready;
  assign s1_adv  = !s1_valid || s2_adv;
  assign issue   = job_valid && s1_adv;
  assign more    = job.touch && job.two && !sel;
  assign job_pop = issue && !more;
  assign rx      = sel ? job.rx1 : job.rx0;
  assign ry      = sel ? job.ry1 : job.ry0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel      <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (issue) begin
        sel <= more;
      end
      if (s1_adv) begin
        s1_valid <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_prod_x <= tfd_pkg::PROD_W'(rx) * tfd_pkg::PROD_W'(panel_width);
      s1_prod_y <= tfd_pkg::PROD_W'(ry) * tfd_pkg::PROD_W'(panel_height);
      s1_down   <= job.touch;
      s1_idx    <= sel;
      s1_last   <= !more;
    end
  end

  assign sx    = s1_prod_x[tfd_pkg::PROD_W-1:tfd_pkg::SCALE_SHIFT];
  assign sy    = s1_prod_y[tfd_pkg::PROD_W-1:tfd_pkg::SCALE_SHIFT];
  assign w_ext = CW'(panel_width);
  assign py    = (w_ext > sx) ? (w_ext - sx) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      touch_down  <= s1_down;
      point_x     <= s1_down ? sy : '0;
      point_y     <= s1_down ? py : '0;
      point_index <= s1_down && s1_idx;
      m_tlast     <= s1_last;
    end
  end

  assign m_tdata = {6'd0, point_y, point_x};
  assign m_tuser = {point_index, touch_down};

  a_no_touch_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !touch_down |-> point_x == '0 && point_y == '0 && !point_index && m_tlast)
    else $error("no-touch result carries coordinates");

  a_second_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && point_index |-> m_tlast)
    else $error("second point not marked last");

  a_sel_two_points: assert property (@(posedge clk) disable iff (rst)
    sel |-> job_valid && job.touch && job.two)
    else $error("second point pending without a two-point job");

  a_issue_has_job: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !$past(s1_valid) |-> $past(job_valid))
    else $error("multiply stage loaded without a job");

endmodule

// ----- rtl/touch_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// touch_frame_decoder
// Assembles 8-byte touch frames and reports up to two rotated, scaled points.
//
//   channel   dir   payload                                  handshake
//   s_*       in    tdata[7:0] data_byte, tuser frame_start  tvalid/tready
//   m_*       out   tdata point_x/point_y, tuser, tlast      tvalid/tready
//   cfg_*     in    cfg_index register, cfg_data value       cfg_valid/cfg_ready
//
// One byte per cycle in; one result per cycle out while m_tready is high.
// A point from the queue head passes the multiply stage, then the output register.
// Input stalls only when the job queue is full and results are not drained.
// Reset is synchronous; width and height return to 600 and 800.
// ----------------------------------------------------------------------------
module touch_frame_decoder #(
  parameter int QUEUE_DEPTH = tfd_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // data_byte[7:0]
  input  logic                            s_tuser,   // frame_start
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,   // point_x[12:0], point_y[25:13]
  output logic                            m_tlast,   // last_point
  output logic [1:0]                      m_tuser,   // touch_down[0], point_index[1]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tfd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tfd_pkg::SIZE_W-1:0]      cfg_data
);

  logic [tfd_pkg::SIZE_W-1:0] panel_width;
  logic [tfd_pkg::SIZE_W-1:0] panel_height;
  logic                       s_accept;
  logic                       push;
  logic                       full;
  logic                       job_valid;
  logic                       job_pop;
  tfd_pkg::job_t              wr_job;
  tfd_pkg::job_t              rd_job;

  assign cfg_ready = 1'b1;
  assign s_tready  = !full;
  assign s_accept  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= tfd_pkg::WIDTH_RESET;
      panel_height <= tfd_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == tfd_pkg::REG_PANEL_WIDTH) begin
        panel_width <= cfg_data;
      end
      if (cfg_index == tfd_pkg::REG_PANEL_HEIGHT) begin
        panel_height <= cfg_data;
      end
    end
  end

  tfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (s_accept),
    .data_byte   (s_tdata),
    .frame_start (s_tuser),
    .push        (push),
    .job         (wr_job)
  );

  tfd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_job   (wr_job),
    .full     (full),
    .pop      (job_pop),
    .rd_valid (job_valid),
    .rd_job   (rd_job)
  );

  tfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .panel_width  (panel_width),
    .panel_height (panel_height),
    .job_valid    (job_valid),
    .job          (rd_job),
    .job_pop      (job_pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .m_tuser      (m_tuser)
  );

endmodule

// ----- verif/touch_frame_decoder_test.sv -----
// ----------------------------------------------------------------------------
// touch_frame_decoder_test
// Self-checking bench for the touch frame decoder. Streams frame bytes with
// random gaps and receiver stalls. A built-in predictor keeps its own frame
// buffer, byte index, checksum and panel size, and queues the rotated, scaled
// points that each completed frame must produce. Results are compared in
// order as they leave the block. Panel size changes only between phases,
// once the block is drained.
// ----------------------------------------------------------------------------
module touch_frame_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD     = 150;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [tfd_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [tfd_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic                        down;
    logic [tfd_pkg::COORD_W-1:0] x;
    logic [tfd_pkg::COORD_W-1:0] y;
    logic                        idx;
    logic                        last;
  } touch_point_t;

  class touch_point_checker;
    logic [7:0]                 frame_mem [tfd_pkg::FRAME_BYTES];
    logic [tfd_pkg::IDX_W-1:0]  byte_pos;
    logic [7:0]                 byte_sum;
    logic [tfd_pkg::SIZE_W-1:0] width;
    logic [tfd_pkg::SIZE_W-1:0] height;
    touch_point_t               expected_points [$];
    int                         mismatches;
    int                         touches_seen;
    int                         no_touch_seen;
    int                         sum_drops;

    function new();
      foreach (frame_mem[i]) frame_mem[i] = '0;
      byte_pos      = '0;
      byte_sum      = '0;
      width         = tfd_pkg::WIDTH_RESET;
      height        = tfd_pkg::HEIGHT_RESET;
      mismatches    = 0;
      touches_seen  = 0;
      no_touch_seen = 0;
      sum_drops     = 0;
    endfunction

    function void write_reg(logic [tfd_pkg::CFG_INDEX_W-1:0] index,
                            logic [tfd_pkg::SIZE_W-1:0] value);
      if (index == tfd_pkg::REG_PANEL_WIDTH) width = value;
      else if (index == tfd_pkg::REG_PANEL_HEIGHT) height = value;
    endfunction

    function touch_point_t scaled_point(int base, logic idx, logic last);
      logic [tfd_pkg::RAW_W-1:0] rx;
      logic [tfd_pkg::RAW_W-1:0] ry;
      int                        sx;
      int                        sy;
      touch_point_t              p;
      rx = {frame_mem[base][7:4], frame_mem[base+1]};
      ry = {frame_mem[base][3:0], frame_mem[base+2]};
      sx = (int'(rx) * int'(width)) >> tfd_pkg::SCALE_SHIFT;
      sy = (int'(ry) * int'(height)) >> tfd_pkg::SCALE_SHIFT;
      p.down = 1'b1;
      p.x    = sy[tfd_pkg::COORD_W-1:0];
      p.y    = (int'(width) > sx) ? tfd_pkg::COORD_W'(int'(width) - sx) : '0;
      p.idx  = idx;
      p.last = last;
      return p;
    endfunction

    function void note_byte(logic [7:0] b, logic start);
      logic [7:0]   hdr;
      touch_point_t none;
      if (start) begin
        byte_pos = '0;
        byte_sum = '0;
      end
      frame_mem[byte_pos] = b;
      byte_sum = byte_sum + b;
      byte_pos = byte_pos + 1'b1;
      if (byte_pos != '0) return;
      if (byte_sum != '0) begin
        byte_sum = '0;
        sum_drops++;
        return;
      end
      hdr = frame_mem[0];
      if (hdr[7:6] != tfd_pkg::HDR_TAG ||
          (hdr[1:0] != tfd_pkg::CNT_ONE && hdr[1:0] != tfd_pkg::CNT_TWO)) begin
        none      = '0;
        none.last = 1'b1;
        expected_points.push_back(none);
      end else if (hdr[1:0] == tfd_pkg::CNT_ONE) begin
        expected_points.push_back(scaled_point(1, 1'b0, 1'b1));
      end else begin
        expected_points.push_back(scaled_point(1, 1'b0, 1'b0));
        expected_points.push_back(scaled_point(4, 1'b1, 1'b1));
      end
    endfunction

    function void check_point(touch_point_t got);
      touch_point_t want;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] unexpected result: down=%0d x=%0d y=%0d idx=%0d last=%0d",
                   $realtime, got.down, got.x, got.y, got.idx, got.last);
        return;
      end
      want = expected_points.pop_front();
      if (want.down) touches_seen++;
      else no_touch_seen++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $write("[%0t] result mismatch: expected down=%0d x=%0d y=%0d idx=%0d last=%0d,",
                 $realtime, want.down, want.x, want.y, want.idx, want.last);
          $display(" got down=%0d x=%0d y=%0d idx=%0d last=%0d",
                   got.down, got.x, got.y, got.idx, got.last);
        end
      end
    endfunction

    function bit at_boundary();
      return byte_pos == '0;
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [7:0]                      s_tdata;
  logic                            s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [31:0]                     m_tdata;
  logic                            m_tlast;
  logic [1:0]                      m_tuser;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [tfd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [tfd_pkg::SIZE_W-1:0]      cfg_data;

  touch_frame_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  touch_point_checker point_check = new();

  logic [7:0] frame_buf [tfd_pkg::FRAME_BYTES];
  int         bytes_sent;
  int         settings_used;
  int         cycle_count;
  int         input_stalls;
  bit         tx_gaps_on;
  bit         rx_gaps_on;
  bit         hold_request;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (s_tvalid && !s_tready) input_stalls++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, point_check.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stalls, one long hold on request.
  initial begin : result_sink
    int           gap;
    touch_point_t got;
    m_tready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        gap = LONG_HOLD;
      end else begin
        gap = rx_gaps_on ? $urandom_range(0, 8) : 0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.down = m_tuser[0];
      got.x    = m_tdata[tfd_pkg::COORD_W-1:0];
      got.y    = m_tdata[2*tfd_pkg::COORD_W-1:tfd_pkg::COORD_W];
      got.idx  = m_tuser[1];
      got.last = m_tlast;
      point_check.check_point(got);
      if ($urandom_range(0, 19) == 0) rx_gaps_on = !rx_gaps_on;
    end
  end

  task automatic send_byte(logic [7:0] b, logic start);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    point_check.note_byte(b, start);
    bytes_sent++;
  endtask

  task automatic send_frame(int n, logic start);
    for (int i = 0; i < n; i++) send_byte(frame_buf[i], (i == 0) ? start : 1'b0);
  endtask

  task automatic seal_frame(bit sum_ok);
    logic [7:0] s;
    s = '0;
    for (int i = 0; i < tfd_pkg::FRAME_BYTES - 1; i++) s = s + frame_buf[i];
    frame_buf[tfd_pkg::FRAME_BYTES-1] = 8'd0 - s;
    if (!sum_ok)
      frame_buf[tfd_pkg::FRAME_BYTES-1] = frame_buf[tfd_pkg::FRAME_BYTES-1] +
                                          8'($urandom_range(1, 255));
  endtask

  task automatic make_frame(logic [7:0] hdr, bit sum_ok);
    bit rails;
    rails = ($urandom_range(0, 4) == 0);
    frame_buf[0] = hdr;
    for (int i = 1; i < tfd_pkg::FRAME_BYTES - 1; i++)
      frame_buf[i] = rails ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom);
    seal_frame(sum_ok);
  endtask

  function automatic logic [7:0] good_header();
    return {tfd_pkg::HDR_TAG, 4'($urandom),
            ($urandom_range(0, 1) ? tfd_pkg::CNT_TWO : tfd_pkg::CNT_ONE)};
  endfunction

  task automatic random_frame();
    int         kind;
    logic       start;
    logic [7:0] hdr;
    kind  = $urandom_range(0, 99);
    start = point_check.at_boundary() ? logic'($urandom_range(0, 1)) : 1'b1;
    if ($urandom_range(0, 9) == 0) tx_gaps_on = !tx_gaps_on;
    if (kind < 60) begin
      make_frame(good_header(), 1'b1);
      send_frame(tfd_pkg::FRAME_BYTES, start);
    end else if (kind < 70) begin
      case ($urandom_range(0, 2))
        0: hdr = '0;
        1: begin
          hdr = 8'($urandom);
          while (hdr[7:6] == tfd_pkg::HDR_TAG) hdr = 8'($urandom);
        end
        default: begin
          hdr = {tfd_pkg::HDR_TAG, 6'($urandom)};
          while (hdr[1:0] == tfd_pkg::CNT_ONE || hdr[1:0] == tfd_pkg::CNT_TWO)
            hdr = {tfd_pkg::HDR_TAG, 6'($urandom)};
        end
      endcase
      make_frame(hdr, 1'b1);
      send_frame(tfd_pkg::FRAME_BYTES, start);
    end else if (kind < 80) begin
      make_frame(good_header(), 1'b0);
      send_frame(tfd_pkg::FRAME_BYTES, start);
    end else if (kind < 90) begin
      make_frame(good_header(), 1'b1);
      send_frame($urandom_range(1, tfd_pkg::FRAME_BYTES - 1), start);
    end else begin
      send_byte(8'($urandom), logic'($urandom_range(0, 1)));
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (point_check.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [tfd_pkg::CFG_INDEX_W-1:0] index,
                           logic [tfd_pkg::SIZE_W-1:0] value, bit more);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
    point_check.write_reg(index, value);
  endtask

  task automatic set_panel(logic [tfd_pkg::SIZE_W-1:0] w, logic [tfd_pkg::SIZE_W-1:0] h);
    write_reg(tfd_pkg::REG_PANEL_WIDTH, w, 1'b1);
    write_reg(tfd_pkg::REG_PANEL_HEIGHT, h, 1'b0);
    settings_used++;
  endtask

  task automatic run_phase(int budget);
    int target;
    target = bytes_sent + budget;
    while (bytes_sent < target) random_frame();
    drain();
  endtask

  task automatic directed_frames();
    // two fingers, raw coordinates at full scale and at zero
    frame_buf[0] = {tfd_pkg::HDR_TAG, 4'h0, tfd_pkg::CNT_TWO};
    for (int i = 1; i <= 3; i++) frame_buf[i] = 8'hFF;
    for (int i = 4; i <= 6; i++) frame_buf[i] = 8'h00;
    seal_frame(1'b1);
    send_frame(tfd_pkg::FRAME_BYTES, 1'b1);
    // all-zero frame: zero header, no touch
    foreach (frame_buf[i]) frame_buf[i] = '0;
    send_frame(tfd_pkg::FRAME_BYTES, 1'b1);
    // cut a frame short with a new start, then one finger
    make_frame(good_header(), 1'b1);
    send_frame(3, 1'b1);
    make_frame({tfd_pkg::HDR_TAG, 4'($urandom), tfd_pkg::CNT_ONE}, 1'b1);
    send_frame(tfd_pkg::FRAME_BYTES, 1'b1);
  endtask

  initial begin : stimulus
    int leftover;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    bytes_sent   = 0;
    cycle_count  = 0;
    input_stalls = 0;
    tx_gaps_on   = 1'b1;
    rx_gaps_on   = 1'b1;
    hold_request = 1'b0;
    settings_used = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_frames();
    drain();
    run_phase(60);

    // full-scale panel; stall the result side while bytes keep coming
    set_panel(12'hFFF, 12'hFFF);
    tx_gaps_on   = 1'b0;
    hold_request = 1'b1;
    run_phase(80);
    tx_gaps_on = 1'b1;

    write_reg(REG_SPARE_LO, 12'($urandom), 1'b1);
    write_reg(REG_SPARE_HI, 12'($urandom), 1'b0);
    set_panel(12'd1, 12'd1);
    run_phase(60);

    set_panel(12'd0, 12'd0);
    run_phase(60);

    repeat (4) begin
      set_panel(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)));
      run_phase(50);
    end

    drain();
    leftover = point_check.pending();
    if (leftover > 0) $display("%0d expected results never arrived", leftover);
    $display("Sent %0d frame bytes over %0d panel settings: %0d touch points, %0d no-touch",
             bytes_sent, settings_used, point_check.touches_seen, point_check.no_touch_seen);
    $display("%0d frames dropped on checksum, %0d input stall cycles, %0d mismatches",
             point_check.sum_drops, input_stalls, point_check.mismatches);
    if (point_check.mismatches == 0 && leftover == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
